FILE: hw/rtl/btmx_pkg.sv
// ----------------------------------------------------------------------------
// btmx_pkg
// Shared sizes, codes and types of the binary trie maximum-xor block.
// ----------------------------------------------------------------------------
package btmx_pkg;

  localparam int KEY_BITS   = 31;
  localparam int NODE_COUNT = 65536;
  localparam int COUNT_BITS = 20;

  localparam int NODE_BITS   = $clog2(NODE_COUNT);
  localparam int FREE_BITS   = NODE_BITS + 1;
  localparam int LEVEL_BITS  = $clog2(KEY_BITS);
  localparam int NEED_BITS   = $clog2(KEY_BITS + 1);
  localparam int KIND_BITS   = 2;
  localparam int STATUS_BITS = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // operation codes
  localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_QUERY  = 2'd2;

  // result codes
  localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd2;

  // one trie node: both child links and both link counts
  typedef struct packed {
    logic [NODE_BITS-1:0]  zero_child;
    logic [NODE_BITS-1:0]  one_child;
    logic [COUNT_BITS-1:0] zero_count;
    logic [COUNT_BITS-1:0] one_count;
  } node_t;

  typedef struct packed {
    logic                 we;
    logic [NODE_BITS-1:0] waddr;
    node_t                wdata;
    logic                 re;
    logic [NODE_BITS-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [KEY_BITS-1:0]    best_xor;
  } result_t;

endpackage

FILE: hw/rtl/binary_trie_max_xor.sv
// ----------------------------------------------------------------------------
// binary_trie_max_xor
// Multiset of 31-bit keys in a binary trie with insert, delete and
// maximum-xor query.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries in_kind (insert, delete, query)
//   and in_key. A transaction is taken when in_valid is high and in_stall low.
//   Output channel out_valid/out_stall returns one result per input
//   transaction: out_status and out_best_xor (zero except for a good query).
//   Items are handled one at a time. The walk does one node-memory read per
//   trie level, so a query walks the trie once and an insert or delete
//   walks it twice (check pass, then update pass); early exits on a missing
//   key, full pool or saturated count end sooner, and an unused kind ends at
//   the root. Results go from the walker register to the output register.
//   A result held in the output register does not block the next input;
//   while the receiver stalls, a finished result waits inside the walker and
//   in_stall stays high.
//   After reset the set is empty and the root node reads as cleared; no
//   clearing pass over the node memory is needed, since new nodes are
//   treated as cleared when taken.
// ----------------------------------------------------------------------------
module binary_trie_max_xor (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [btmx_pkg::KIND_BITS-1:0]      in_kind,
  input  logic [btmx_pkg::KEY_BITS-1:0]       in_key,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [btmx_pkg::STATUS_BITS-1:0]    out_status,
  output logic [btmx_pkg::KEY_BITS-1:0]       out_best_xor
);
  import btmx_pkg::*;

  mem_req_t req;
  node_t    rdata;
  logic     res_valid, res_take;
  result_t  res;

  logic     out_valid_r, out_valid_nxt;
  result_t  out_r;

  btmx_node_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  btmx_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .in_key    (in_key),
    .req       (req),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // output register frees up when empty or its transaction completes
  assign res_take      = res_valid && (!out_valid_r || !out_stall);
  assign out_valid_nxt = res_take || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_r.status;
  assign out_best_xor = out_r.best_xor;

endmodule

FILE: hw/rtl/btmx_node_ram.sv
// ----------------------------------------------------------------------------
// btmx_node_ram
// Single-port-per-direction node store, one write and one registered read.
// ----------------------------------------------------------------------------
module btmx_node_ram (
  input  logic              clk,
  input  btmx_pkg::mem_req_t req,
  output btmx_pkg::node_t   rdata
);
  import btmx_pkg::*;

  node_t mem [NODE_COUNT];
  node_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/btmx_walk.sv
// ----------------------------------------------------------------------------
// btmx_walk
// Trie walker: one node read per level, check pass and update pass for
// insert and delete, single pass for query.
// ----------------------------------------------------------------------------
module btmx_walk (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [btmx_pkg::KIND_BITS-1:0]    in_kind,
  input  logic [btmx_pkg::KEY_BITS-1:0]     in_key,
  output btmx_pkg::mem_req_t                req,
  input  btmx_pkg::node_t                   rdata,
  output logic                              res_valid,
  output btmx_pkg::result_t                 res,
  input  logic                              res_take
);
  import btmx_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_PUT  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [FREE_BITS-1:0]  free_r, free_nxt;
  logic                  root_ok_r, root_ok_nxt;
  logic [KIND_BITS-1:0]  kind_r, kind_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [LEVEL_BITS-1:0] level_r, level_nxt;
  logic [NODE_BITS-1:0]  node_r, node_nxt;
  logic                  pass_r, pass_nxt;
  logic                  fresh_r, fresh_nxt;
  logic [KEY_BITS-1:0]   ans_r, ans_nxt;
  result_t               res_r, res_nxt;

  node_t                 ent, wr_ent;
  logic [LEVEL_BITS-1:0] idx;
  logic                  b, last;
  logic [NODE_BITS-1:0]  child_b, child_nb, nn;
  logic [COUNT_BITS-1:0] cnt_b, cnt_nb;
  logic [KEY_BITS-1:0]   bit_mask;
  logic [NEED_BITS-1:0]  needed;
  logic [FREE_BITS:0]    need_sum;
  logic                  go_step, go_restart, go_finish, go_alloc;
  logic [STATUS_BITS-1:0] fin_status;
  logic [KEY_BITS-1:0]   fin_best;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      free_r    <= FREE_BITS'(1);
      root_ok_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      free_r    <= free_nxt;
      root_ok_r <= root_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    key_r   <= key_nxt;
    level_r <= level_nxt;
    node_r  <= node_nxt;
    pass_r  <= pass_nxt;
    fresh_r <= fresh_nxt;
    ans_r   <= ans_nxt;
    res_r   <= res_nxt;
  end

  // root reads as cleared until first written, new nodes read as cleared
  assign ent = (fresh_r || (node_r == '0 && !root_ok_r)) ? '0 : rdata;

  assign idx      = LEVEL_BITS'(KEY_BITS - 1) - level_r;
  assign b        = key_r[idx];
  assign last     = (level_r == LEVEL_BITS'(KEY_BITS - 1));
  assign child_b  = b ? ent.one_child  : ent.zero_child;
  assign child_nb = b ? ent.zero_child : ent.one_child;
  assign cnt_b    = b ? ent.one_count  : ent.zero_count;
  assign cnt_nb   = b ? ent.zero_count : ent.one_count;
  assign bit_mask = KEY_BITS'(1) << idx;
  assign needed   = NEED_BITS'(KEY_BITS) - NEED_BITS'(level_r);
  assign need_sum = {1'b0, free_r} + (FREE_BITS + 1)'(needed);

  always_comb begin
    go_step    = 1'b0;
    go_restart = 1'b0;
    go_finish  = 1'b0;
    go_alloc   = 1'b0;
    fin_status = ST_OK;
    fin_best   = '0;
    nn         = child_b;
    wr_ent     = ent;

    unique case (kind_r)
      KIND_QUERY: begin
        if (level_r == '0 && ent.zero_count == '0 && ent.one_count == '0) begin
          go_finish  = 1'b1;
          fin_status = ST_MISS;
        end else begin
          if (child_nb != '0 && cnt_nb != '0) begin
            nn = child_nb;
          end
          if (last) begin
            go_finish = 1'b1;
            fin_best  = (child_nb != '0 && cnt_nb != '0) ? (ans_r | bit_mask) : ans_r;
          end else begin
            go_step = 1'b1;
          end
        end
      end
      KIND_DELETE: begin
        if (!pass_r) begin
          if (child_b == '0 || cnt_b == '0) begin
            go_finish  = 1'b1;
            fin_status = ST_MISS;
          end else if (last) begin
            go_restart = 1'b1;
          end else begin
            go_step = 1'b1;
          end
        end else begin
          if (b) wr_ent.one_count = cnt_b - COUNT_BITS'(1);
          else   wr_ent.zero_count = cnt_b - COUNT_BITS'(1);
          if (last) go_finish = 1'b1;
          else      go_step = 1'b1;
        end
      end
      KIND_INSERT: begin
        if (!pass_r) begin
          if (cnt_b == COUNT_MAX) begin
            go_finish  = 1'b1;
            fin_status = ST_FULL;
          end else if (child_b == '0) begin
            if (need_sum > (FREE_BITS + 1)'(NODE_COUNT)) begin
              go_finish  = 1'b1;
              fin_status = ST_FULL;
            end else begin
              go_restart = 1'b1;
            end
          end else if (last) begin
            go_restart = 1'b1;
          end else begin
            go_step = 1'b1;
          end
        end else begin
          if (child_b == '0) begin
            go_alloc = 1'b1;
            nn       = free_r[NODE_BITS-1:0];
          end
          if (b) begin
            wr_ent.one_child = nn;
            wr_ent.one_count = cnt_b + COUNT_BITS'(1);
          end else begin
            wr_ent.zero_child = nn;
            wr_ent.zero_count = cnt_b + COUNT_BITS'(1);
          end
          if (last) go_finish = 1'b1;
          else      go_step = 1'b1;
        end
      end
      default: begin
        go_finish = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    free_nxt    = free_r;
    root_ok_nxt = root_ok_r;
    kind_nxt    = kind_r;
    key_nxt     = key_r;
    level_nxt   = level_r;
    node_nxt    = node_r;
    pass_nxt    = pass_r;
    fresh_nxt   = fresh_r;
    ans_nxt     = ans_r;
    res_nxt     = res_r;
    req         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          key_nxt   = in_key;
          level_nxt = '0;
          node_nxt  = '0;
          pass_nxt  = 1'b0;
          fresh_nxt = 1'b0;
          ans_nxt   = '0;
          req.re    = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        // write back only in the update pass
        if (pass_r) begin
          req.we    = 1'b1;
          req.waddr = node_r;
          req.wdata = wr_ent;
          if (node_r == '0) root_ok_nxt = 1'b1;
        end
        if (kind_r == KIND_QUERY && nn == child_nb && child_nb != '0 && cnt_nb != '0) begin
          ans_nxt = ans_r | bit_mask;
        end
        if (go_alloc) begin
          free_nxt = free_r + FREE_BITS'(1);
        end
        if (go_step) begin
          level_nxt = level_r + LEVEL_BITS'(1);
          node_nxt  = nn;
          fresh_nxt = go_alloc | fresh_r;
          req.re    = 1'b1;
          req.raddr = nn;
        end else if (go_restart) begin
          level_nxt = '0;
          node_nxt  = '0;
          pass_nxt  = 1'b1;
          fresh_nxt = 1'b0;
          req.re    = 1'b1;
        end else if (go_finish) begin
          res_nxt.status   = fin_status;
          res_nxt.best_xor = fin_best;
          state_nxt        = S_PUT;
        end
      end
      S_PUT: begin
        if (res_take) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_PUT);
  assign res       = res_r;

endmodule

FILE: hw/rtl/btmx_checker.sv
// ----------------------------------------------------------------------------
// btmx_checker
// Port-level checks of the trie block, bound to the top level.
// ----------------------------------------------------------------------------
module btmx_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic [btmx_pkg::KIND_BITS-1:0]      in_kind,
  input logic [btmx_pkg::KEY_BITS-1:0]       in_key,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [btmx_pkg::STATUS_BITS-1:0]    out_status,
  input logic [btmx_pkg::KEY_BITS-1:0]       out_best_xor
);
  import btmx_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled input transaction keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_kind) && $stable(in_key))
    else $error("input payload changed while stalled");

  // only a good result carries an xor value
  a_best_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_best_xor == '0)
    else $error("nonzero xor on a failed transaction");

  // one item at a time: busy right after a transaction is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken back to back");

  // reset empties the output register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind binary_trie_max_xor btmx_checker u_btmx_checker (.*);

FILE: dv/trie_xor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trie_xor_checker
// Watches both channels of the trie block and keeps its own copy of the trie.
// Each accepted transaction on the input channel is run through that copy to
// produce the expected status and best xor. Each accepted result is then
// compared against the oldest expected result still waiting.
// ----------------------------------------------------------------------------
module trie_xor_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [btmx_pkg::KIND_BITS-1:0]   in_kind,
  input  logic [btmx_pkg::KEY_BITS-1:0]    in_key,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [btmx_pkg::STATUS_BITS-1:0] out_status,
  input  logic [btmx_pkg::KEY_BITS-1:0]    out_best_xor,
  output int                               fail_count,
  output int                               pending
);

  import btmx_pkg::*;

  typedef struct {
    logic [KIND_BITS-1:0] kind;
    logic [KEY_BITS-1:0]  key;
    result_t              res;
  } trie_op_t;

  logic [NODE_BITS-1:0]  zero_link  [NODE_COUNT];
  logic [NODE_BITS-1:0]  one_link   [NODE_COUNT];
  logic [COUNT_BITS-1:0] zero_tally [NODE_COUNT];
  logic [COUNT_BITS-1:0] one_tally  [NODE_COUNT];
  int unsigned           free_node;

  trie_op_t expected_q[$];
  int       errs = 0;

  function automatic logic [STATUS_BITS-1:0] trie_insert(logic [KEY_BITS-1:0] key);
    int unsigned node;
    int unsigned child;
    int unsigned need;
    int          lvl;
    logic        bit_val;
    node = 0;
    need = 0;
    // first walk: saturated counts on the path and nodes still missing
    for (lvl = 0; lvl < KEY_BITS; lvl++) begin
      bit_val = key[KEY_BITS-1-lvl];
      child   = bit_val ? one_link[node] : zero_link[node];
      if ((bit_val ? one_tally[node] : zero_tally[node]) == COUNT_MAX) return ST_FULL;
      if (child == 0) begin
        need = KEY_BITS - lvl;
        break;
      end
      node = child;
    end
    if (free_node + need > NODE_COUNT) return ST_FULL;
    node = 0;
    for (lvl = 0; lvl < KEY_BITS; lvl++) begin
      bit_val = key[KEY_BITS-1-lvl];
      child   = bit_val ? one_link[node] : zero_link[node];
      if (child == 0) begin
        child = free_node;
        free_node++;
        zero_link[child]  = '0;
        one_link[child]   = '0;
        zero_tally[child] = '0;
        one_tally[child]  = '0;
        if (bit_val) one_link[node] = child[NODE_BITS-1:0];
        else zero_link[node] = child[NODE_BITS-1:0];
      end
      if (bit_val) one_tally[node] = one_tally[node] + 1'b1;
      else zero_tally[node] = zero_tally[node] + 1'b1;
      node = child;
    end
    return ST_OK;
  endfunction

  function automatic logic [STATUS_BITS-1:0] trie_delete(logic [KEY_BITS-1:0] key);
    int unsigned node;
    int unsigned child;
    int          lvl;
    logic        bit_val;
    node = 0;
    for (lvl = 0; lvl < KEY_BITS; lvl++) begin
      bit_val = key[KEY_BITS-1-lvl];
      child   = bit_val ? one_link[node] : zero_link[node];
      if (child == 0 || (bit_val ? one_tally[node] : zero_tally[node]) == 0) return ST_MISS;
      node = child;
    end
    node = 0;
    for (lvl = 0; lvl < KEY_BITS; lvl++) begin
      bit_val = key[KEY_BITS-1-lvl];
      child   = bit_val ? one_link[node] : zero_link[node];
      if (bit_val) one_tally[node] = one_tally[node] - 1'b1;
      else zero_tally[node] = zero_tally[node] - 1'b1;
      node = child;
    end
    return ST_OK;
  endfunction

  function automatic result_t trie_best_xor(logic [KEY_BITS-1:0] key);
    result_t     res;
    int unsigned node;
    int unsigned child;
    int          lvl;
    logic        bit_val;
    res.status   = ST_OK;
    res.best_xor = '0;
    if (zero_tally[0] == 0 && one_tally[0] == 0) begin
      res.status = ST_MISS;
      return res;
    end
    node = 0;
    for (lvl = 0; lvl < KEY_BITS; lvl++) begin
      bit_val = key[KEY_BITS-1-lvl];
      // steer toward the opposite bit while a live link exists
      child = bit_val ? zero_link[node] : one_link[node];
      if (child != 0 && (bit_val ? zero_tally[node] : one_tally[node]) != 0) begin
        res.best_xor[KEY_BITS-1-lvl] = 1'b1;
        node = child;
      end else begin
        node = bit_val ? one_link[node] : zero_link[node];
      end
    end
    return res;
  endfunction

  function automatic void log_failure(string msg);
    errs++;
    if (errs <= 10) $display("ERROR: %s", msg);
  endfunction

  always @(posedge clk) begin : watch
    trie_op_t pend;
    if (!rst_n) begin
      expected_q.delete();
      free_node     = 1;
      zero_link[0]  = '0;
      one_link[0]   = '0;
      zero_tally[0] = '0;
      one_tally[0]  = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          log_failure($sformatf("unexpected result: status %0d best_xor %h",
                                out_status, out_best_xor));
        end else begin
          pend = expected_q.pop_front();
          if (out_status !== pend.res.status || out_best_xor !== pend.res.best_xor) begin
            log_failure($sformatf(
              "kind %0d key %h: expected status %0d best_xor %h, got status %0d best_xor %h",
              pend.kind, pend.key, pend.res.status, pend.res.best_xor,
              out_status, out_best_xor));
          end
        end
      end
      if (in_valid && !in_stall) begin
        pend.kind         = in_kind;
        pend.key          = in_key;
        pend.res.status   = ST_OK;
        pend.res.best_xor = '0;
        case (in_kind)
          KIND_INSERT: pend.res.status = trie_insert(in_key);
          KIND_DELETE: pend.res.status = trie_delete(in_key);
          KIND_QUERY:  pend.res = trie_best_xor(in_key);
          default: ;
        endcase
        expected_q.insert(expected_q.size(), pend);
      end
    end
    fail_count <= errs;
    pending    <= expected_q.size();
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the binary trie maximum-xor block.
// A directed opening covers empty-set queries, absent deletes, duplicate keys
// and the unused operation code. Random rounds then mix inserts, deletes and
// queries around stored keys, each round draining the set to empty. A final
// fill with spread-out keys builds a wide trie, followed by mixed traffic
// on it. Both channels idle and stall at random; the checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module testbench;

  import btmx_pkg::*;

  localparam logic [KIND_BITS-1:0] KIND_SPARE = 2'd3;
  localparam int FILL_KEYS = 100;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic [KIND_BITS-1:0]   in_kind   = KIND_INSERT;
  logic [KEY_BITS-1:0]    in_key    = '0;
  logic                   out_stall = 1'b0;
  logic                   in_stall;
  logic                   out_valid;
  logic [STATUS_BITS-1:0] out_status;
  logic [KEY_BITS-1:0]    out_best_xor;
  int                     fail_count;
  int                     pending;

  bit                     in_idle    = 1'b0;
  bit                     stall_idle = 1'b0;
  bit                     track_live = 1'b1;
  logic [KEY_BITS-1:0]    live_keys[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  binary_trie_max_xor DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_key       (in_key),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_best_xor (out_best_xor)
  );

  trie_xor_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_key       (in_key),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_best_xor (out_best_xor),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // bit-reversed index: neighbors split near the root, so each key costs many nodes
  function automatic logic [KEY_BITS-1:0] spread_key(int n);
    logic [KEY_BITS-1:0] key;
    int                  b;
    for (b = 0; b < KEY_BITS; b++) key[KEY_BITS-1-b] = n[b];
    return key;
  endfunction

  task automatic issue(input logic [KIND_BITS-1:0] kind, input logic [KEY_BITS-1:0] key);
    int gap;
    int idx;
    gap = in_idle ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_key   <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (track_live) begin
      if (kind == KIND_INSERT) begin
        live_keys.insert(live_keys.size(), key);
      end else if (kind == KIND_DELETE) begin
        idx = -1;
        foreach (live_keys[i]) if (idx < 0 && live_keys[i] == key) idx = i;
        if (idx >= 0) live_keys.delete(idx);
      end
    end
  endtask

  task automatic random_op();
    int                  r;
    logic [KEY_BITS-1:0] known;
    logic [KEY_BITS-1:0] key;
    r     = $urandom_range(0, 99);
    known = live_keys.size() ? live_keys[$urandom_range(0, live_keys.size() - 1)]
                             : KEY_BITS'($urandom());
    key   = known;
    case ($urandom_range(0, 3))
      0: key = KEY_BITS'($urandom());
      // shares a prefix with a stored key, then departs
      1: key = known ^ (31'd1 << $urandom_range(0, KEY_BITS - 1));
      default: ;
    endcase
    if (r < 40) issue(KIND_INSERT, key);
    else if (r < 68) issue(KIND_DELETE, key);
    else if (r < 95) issue(KIND_QUERY, $urandom_range(0, 1) ? ~key : KEY_BITS'($urandom()));
    else issue(KIND_SPARE, KEY_BITS'($urandom()));
  endtask

  initial begin : stall_gen
    int hold;
    forever begin
      if (stall_idle && $urandom_range(0, 2) == 0) begin
        hold = idle_len() + 1;
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  initial begin : stimulus
    int round;
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle    = 1'b1;
    stall_idle = 1'b1;
    issue(KIND_QUERY,  31'h0000_0000);   // empty set
    issue(KIND_DELETE, 31'h7FFF_FFFF);   // nothing stored
    issue(KIND_INSERT, 31'h0000_0000);
    issue(KIND_INSERT, 31'h7FFF_FFFF);
    issue(KIND_QUERY,  31'h0000_0000);
    issue(KIND_QUERY,  31'h7FFF_FFFF);
    issue(KIND_QUERY,  31'h2AAA_AAAA);
    issue(KIND_INSERT, 31'h0000_0000);   // duplicate key
    issue(KIND_DELETE, 31'h7FFF_FFFF);
    issue(KIND_QUERY,  31'h7FFF_FFFF);
    issue(KIND_DELETE, 31'h7FFF_FFFF);   // path exists but its count is zero
    issue(KIND_DELETE, 31'h0000_0001);   // absent, shares a long prefix
    issue(KIND_DELETE, 31'h0000_0000);
    issue(KIND_QUERY,  31'h5555_5555);
    issue(KIND_DELETE, 31'h0000_0000);
    issue(KIND_QUERY,  31'h0000_0000);   // empty again with nodes left behind
    issue(KIND_SPARE,  31'h7FFF_FFFF);
    issue(KIND_SPARE,  31'h0000_0000);
    issue(KIND_INSERT, 31'h4000_0000);
    issue(KIND_INSERT, 31'h3FFF_FFFF);
    issue(KIND_QUERY,  31'h0000_0000);
    issue(KIND_QUERY,  31'h7FFF_FFFF);

    for (round = 0; round < 4; round++) begin
      in_idle    = (round == 1) || (round > 1 && $urandom_range(0, 3) != 0);
      stall_idle = (round == 1) || (round > 1 && $urandom_range(0, 3) != 0);
      repeat (100) random_op();
      while (live_keys.size() != 0)
        issue(KIND_DELETE, live_keys[$urandom_range(0, live_keys.size() - 1)]);
      issue(KIND_QUERY, KEY_BITS'($urandom()));
    end

    // wide trie from spread-out keys, back to back at first
    track_live = 1'b0;
    in_idle    = 1'b0;
    stall_idle = 1'b0;
    for (n = 0; n < FILL_KEYS; n++) begin
      if (n == FILL_KEYS / 2) stall_idle = 1'b1;
      issue(KIND_INSERT, spread_key(n));
    end

    in_idle = 1'b1;
    for (n = 0; n < 40; n++) begin
      case ($urandom_range(0, 3))
        0: issue(KIND_INSERT, spread_key($urandom_range(0, FILL_KEYS - 1)));
        1: issue(KIND_DELETE, spread_key($urandom_range(0, FILL_KEYS - 1)));
        2: issue(KIND_QUERY, KEY_BITS'($urandom()));
        default: random_op();
      endcase
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #60_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/btmx_pkg.sv
hw/rtl/btmx_node_ram.sv
hw/rtl/btmx_walk.sv
hw/rtl/binary_trie_max_xor.sv
hw/rtl/btmx_checker.sv
dv/trie_xor_checker.sv
dv/testbench.sv
